[rtl/nsgf_pkg.sv]
// Shared constants, types and codes for the near-square grid fit block.
`default_nettype none
package nsgf_pkg;

   localparam int CNT_W     = 16;                  // width of counts and dimensions
   localparam int SQ_W      = (CNT_W + 1) / 2;     // width of the square root
   localparam int RAD_W     = 2 * SQ_W;            // radicand padded to whole digit pairs
   localparam int STEP_CW   = $clog2(CNT_W + 1);   // step counter width for mul / div
   localparam int SQ_STEP_CW = $clog2(SQ_W + 1);   // step counter width for sqrt

   localparam logic [STEP_CW-1:0]    CNT_STEPS = STEP_CW'(CNT_W);
   localparam logic [SQ_STEP_CW-1:0] SQ_STEPS  = SQ_STEP_CW'(SQ_W);
   localparam logic [CNT_W-1:0]      LINEAR_LIMIT = CNT_W'(20);
   localparam logic [CNT_W-1:0]      ONE_CNT      = CNT_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIT,
      ST_DIVS_GO,
      ST_DIVS_WAIT,
      ST_DIVY_GO,
      ST_DIVY_WAIT,
      ST_OUT
   } fit_state_type;

   // result handed back by the shared divider
   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] quot;
      logic             rem_zero;
   } div_res_type;

endpackage
`default_nettype wire

[rtl/nsgf_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none
module nsgf_mul
   import nsgf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [CNT_W-1:0]     a,
   input  wire logic [CNT_W-1:0]     b,
   output logic                      busy,
   output logic [2*CNT_W-1:0]        product
);

   logic [2*CNT_W-1:0] a_ff;
   logic [CNT_W-1:0]   b_ff;
   logic [2*CNT_W-1:0] acc_ff;
   logic [STEP_CW-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_STEPS;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - STEP_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= {{CNT_W{1'b0}}, a};
         b_ff   <= b;
         acc_ff <= '0;
      end else if (cnt_ff != '0) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= {a_ff[2*CNT_W-2:0], 1'b0};
         b_ff <= {1'b0, b_ff[CNT_W-1:1]};
      end
   end

   assign busy    = (cnt_ff != '0);
   assign product = acc_ff;

endmodule
`default_nettype wire

[rtl/nsgf_isqrt.sv]
// Digit-by-digit integer floor square root, one root bit per cycle.
`default_nettype none
module nsgf_isqrt
   import nsgf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [CNT_W-1:0]     radicand,
   output logic                      busy,
   output logic [SQ_W-1:0]           root
);

   logic [RAD_W-1:0]      rad_ff;
   logic [SQ_W:0]         rem_ff;
   logic [SQ_W-1:0]       root_ff;
   logic [SQ_STEP_CW-1:0] cnt_ff;
   logic [SQ_W+2:0]       shifted;
   logic [SQ_W+2:0]       trial;
   logic [SQ_W+2:0]       diff;
   logic                  fits;

   // bring down the next pair of radicand bits, try root*4+1
   assign shifted = {rem_ff, rad_ff[RAD_W-1:RAD_W-2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign diff    = shifted - trial;
   assign fits    = (shifted >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= SQ_STEPS;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - SQ_STEP_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= RAD_W'(radicand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cnt_ff != '0) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         // remainder stays below 2*root+1, so it needs SQ_W+1 bits
         if (fits) begin
            rem_ff  <= diff[SQ_W:0];
            root_ff <= {root_ff[SQ_W-2:0], 1'b1};
         end else begin
            rem_ff  <= shifted[SQ_W:0];
            root_ff <= {root_ff[SQ_W-2:0], 1'b0};
         end
      end
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff;

endmodule
`default_nettype wire

[rtl/nsgf_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module nsgf_div
   import nsgf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [CNT_W-1:0]     dividend,
   input  wire logic [CNT_W-1:0]     divisor,
   output div_res_type               res
);

   logic [CNT_W-1:0]   quot_ff;
   logic [CNT_W-1:0]   rem_ff;
   logic [CNT_W-1:0]   dsr_ff;
   logic [STEP_CW-1:0] cnt_ff;
   logic [CNT_W:0]     trial;
   logic [CNT_W:0]     diff;
   logic               ge;

   // quot_ff starts as the dividend and fills with quotient bits from the bottom
   assign trial = {rem_ff, quot_ff[CNT_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_STEPS;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - STEP_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
      end else if (cnt_ff != '0) begin
         quot_ff <= {quot_ff[CNT_W-2:0], ge};
         rem_ff  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      end
   end

   assign res.busy     = (cnt_ff != '0);
   assign res.quot     = quot_ff;
   assign res.rem_zero = (rem_ff == '0);

endmodule
`default_nettype wire

[rtl/near_square_grid_fit_core.sv]
// When the current grid fits, the product settles the request; else divisions run one after another on the
// shared bit-serial divider (one at s = floor(sqrt(n)), then one per tried height),
// with at most 2s - s/2 + 2 divisions in all.
// Throughput: one request at a time; the next is taken as soon as the result is registered.
// Reset (synchronous, active high) clears the sequencer and the result valid; no memories.
`default_nettype none
module near_square_grid_fit_core
   import nsgf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CNT_W-1:0]  req_n,
   input  wire logic [CNT_W-1:0]  req_cur_x,
   input  wire logic [CNT_W-1:0]  req_cur_y,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CNT_W-1:0]       rsp_grid_x,
   output logic [CNT_W-1:0]       rsp_grid_y,
   output logic                   rsp_changed
);

   fit_state_type state_ff, state_in;

   logic [CNT_W-1:0] n_ff, cx_ff, cy_ff;
   logic [CNT_W-1:0] s_ff, y_ff, hi_ff, qs_ff;
   logic [CNT_W-1:0] res_x_ff, res_y_ff;
   logic             res_chg_ff;
   logic             rsp_valid_ff;
   logic [CNT_W-1:0] rsp_x_ff, rsp_y_ff;
   logic             rsp_chg_ff;

   logic             accept;
   logic             out_free;
   logic             mul_busy, sq_busy;
   logic [2*CNT_W-1:0] product;
   logic [SQ_W-1:0]  root;
   div_res_type      div_res;
   logic             div_start;
   logic [CNT_W-1:0] divisor;

   logic             fit_ready, fit_match;
   logic             res_load;
   logic [CNT_W-1:0] res_x_in, res_y_in;
   logic             res_chg_in;
   logic             s_load, loop_init, y_step;
   logic [CNT_W-1:0] s_in, half_s;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // multiplier and square root start together; the root is done well before the product
   nsgf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .a       (req_cur_x),
      .b       (req_cur_y),
      .busy    (mul_busy),
      .product (product)
   );

   nsgf_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .radicand (req_n),
      .busy     (sq_busy),
      .root     (root)
   );

   assign divisor = (state_ff == ST_DIVS_GO) ? s_ff : y_ff;

   nsgf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (n_ff),
      .divisor  (divisor),
      .res      (div_res)
   );

   assign fit_ready = !mul_busy && !sq_busy;
   assign fit_match = (product == {{CNT_W{1'b0}}, n_ff});
   assign s_in      = (root == '0) ? ONE_CNT : CNT_W'(root);
   assign half_s    = {1'b0, s_ff[CNT_W-1:1]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_FIT;
         end
         ST_FIT: begin
            if (fit_ready) state_in = fit_match ? ST_OUT : ST_DIVS_GO;
         end
         ST_DIVS_GO: state_in = ST_DIVS_WAIT;
         ST_DIVS_WAIT: begin
            if (!div_res.busy) state_in = div_res.rem_zero ? ST_OUT : ST_DIVY_GO;
         end
         ST_DIVY_GO: state_in = ST_DIVY_WAIT;
         ST_DIVY_WAIT: begin
            if (!div_res.busy) begin
               state_in = (div_res.rem_zero || y_ff == hi_ff) ? ST_OUT : ST_DIVY_GO;
            end
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      div_start  = 1'b0;
      res_load   = 1'b0;
      res_x_in   = n_ff;
      res_y_in   = ONE_CNT;
      res_chg_in = 1'b1;
      s_load     = 1'b0;
      loop_init  = 1'b0;
      y_step     = 1'b0;
      case (state_ff)
         ST_FIT: begin
            if (fit_ready) begin
               if (fit_match) begin
                  res_load   = 1'b1;
                  res_x_in   = cx_ff;
                  res_y_in   = cy_ff;
                  res_chg_in = 1'b0;
               end else begin
                  s_load = 1'b1;
               end
            end
         end
         ST_DIVS_GO, ST_DIVY_GO: div_start = 1'b1;
         ST_DIVS_WAIT: begin
            if (!div_res.busy) begin
               if (div_res.rem_zero) begin
                  res_load = 1'b1;
                  res_x_in = div_res.quot;
                  res_y_in = s_ff;
               end else begin
                  loop_init = 1'b1;
               end
            end
         end
         ST_DIVY_WAIT: begin
            if (!div_res.busy) begin
               if (div_res.rem_zero) begin
                  res_load = 1'b1;
                  res_x_in = div_res.quot;
                  res_y_in = y_ff;
               end else if (y_ff == hi_ff) begin
                  // no divisor in range: linear for small n, else s rows of ceil(n/s)
                  res_load = 1'b1;
                  if (n_ff >= LINEAR_LIMIT) begin
                     res_x_in = qs_ff + ONE_CNT;
                     res_y_in = s_ff;
                  end
               end else begin
                  y_step = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         n_ff  <= req_n;
         cx_ff <= req_cur_x;
         cy_ff <= req_cur_y;
      end
      if (s_load) begin
         s_ff <= s_in;
      end
      if (loop_init) begin
         qs_ff <= div_res.quot;
         y_ff  <= (half_s == '0) ? ONE_CNT : half_s;
         hi_ff <= {s_ff[CNT_W-2:0], 1'b0};
      end else if (y_step) begin
         y_ff <= y_ff + ONE_CNT;
      end
      if (res_load) begin
         res_x_ff   <= res_x_in;
         res_y_ff   <= res_y_in;
         res_chg_ff <= res_chg_in;
      end
   end

   // output register: holds the response until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_x_ff   <= res_x_ff;
         rsp_y_ff   <= res_y_ff;
         rsp_chg_ff <= res_chg_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_grid_x  = rsp_x_ff;
   assign rsp_grid_y  = rsp_y_ff;
   assign rsp_changed = rsp_chg_ff;

endmodule
`default_nettype wire
